@@ design/mcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared widths, types and helpers for the monotone cubic segment builder.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int POINT_BITS = 16;
  localparam int COEF_BITS  = 32;
  // Quotient bits the divider develops; anything wider saturates anyway.
  localparam int QUO_BITS   = COEF_BITS + 1;
  localparam int MUL_BITS   = (COEF_BITS > POINT_BITS + 3) ? COEF_BITS : POINT_BITS + 3;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  localparam int DEN_BITS   = COEF_BITS + POINT_BITS + 3;
  localparam int NUM_BITS   = DEN_BITS + QUO_BITS;
  localparam int EXT_BITS   = COEF_BITS + 3;
  localparam int CNT_BITS   = $clog2(QUO_BITS + 1);

  typedef struct packed {
    logic                  start;
    logic                  neg;
    logic [NUM_BITS-1:0]   num;
    logic [DEN_BITS-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [COEF_BITS-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [POINT_BITS-1:0]       seg_x;
    logic [POINT_BITS-1:0]       seg_y;
    logic signed [COEF_BITS-1:0] tangent;
    logic signed [COEF_BITS-1:0] quad_coef;
    logic signed [COEF_BITS-1:0] cubic_coef;
    logic                        last_segment;
  } seg_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHK,
    DV_RUN,
    DV_FIN
  } div_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SLOPE,
    S_SLOPE_W,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_TDIV,
    S_TDIV_W,
    S_SETUP_A,
    S_UPDATE,
    S_QDIV,
    S_QDIV_W,
    S_SQ0,
    S_SQ1,
    S_CDIV,
    S_CDIV_W,
    S_WRITE
  } seq_state_t;

  // Magnitude of a coefficient; the most negative value maps to 2^(COEF_BITS-1).
  function automatic logic [COEF_BITS-1:0] coef_mag(input logic [COEF_BITS-1:0] v);
    logic [COEF_BITS-1:0] r;
    r = v[COEF_BITS-1] ? (~v + COEF_BITS'(1)) : v;
    return r;
  endfunction

  function automatic logic [EXT_BITS-1:0] ext_mag(input logic [EXT_BITS-1:0] v);
    logic [EXT_BITS-1:0] r;
    r = v[EXT_BITS-1] ? (~v + EXT_BITS'(1)) : v;
    return r;
  endfunction

endpackage

@@ design/mcs_div.sv @@
// ----------------------------------------------------------------------------
// mcs_div
// Iterative restoring divider: signed, truncating, saturating quotient of
// two magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcs_div (
  input  logic              clk,
  input  logic              rst,
  input  mcs_pkg::div_req_t req,
  output mcs_pkg::div_rsp_t rsp
);
  import mcs_pkg::*;

  div_state_t            state;
  div_state_t            state_next;
  logic                  neg_r;
  logic                  sat;
  logic [NUM_BITS-1:0]   num_r;
  logic [DEN_BITS-1:0]   den_r;
  logic [DEN_BITS-1:0]   rem;
  logic [QUO_BITS-1:0]   sh;
  logic [CNT_BITS-1:0]   cnt;
  logic [DEN_BITS:0]     trial_in;
  logic [DEN_BITS:0]     trial;
  logic                  ge;
  logic [QUO_BITS-1:0]   lim;
  logic [QUO_BITS-1:0]   mag;
  logic                  done;
  logic [COEF_BITS-1:0]  quo;

  assign trial_in = {rem, sh[QUO_BITS-1]};
  assign ge       = trial_in >= {1'b0, den_r};
  assign trial    = trial_in - {1'b0, den_r};
  assign lim      = neg_r ? (QUO_BITS'(1) << (COEF_BITS - 1))
                          : ((QUO_BITS'(1) << (COEF_BITS - 1)) - QUO_BITS'(1));
  assign mag      = (sat || (sh > lim)) ? lim : sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: if (req.start) state_next = DV_CHK;
      DV_CHK: begin
        if (num_r == '0 || den_r == '0 || num_r >= {den_r, {QUO_BITS{1'b0}}}) begin
          state_next = DV_FIN;
        end else begin
          state_next = DV_RUN;
        end
      end
      DV_RUN: if (cnt == CNT_BITS'(1)) state_next = DV_FIN;
      DV_FIN: state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == DV_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DV_IDLE: begin
        if (req.start) begin
          neg_r <= req.neg;
          num_r <= req.num;
          den_r <= req.den;
        end
      end
      DV_CHK: begin
        // A zero numerator gives zero; a zero or too small divisor saturates.
        sat <= (num_r != '0) && ((den_r == '0) || (num_r >= {den_r, {QUO_BITS{1'b0}}}));
        sh  <= (num_r == '0) ? '0 : num_r[QUO_BITS-1:0];
        rem <= num_r[NUM_BITS-1:QUO_BITS];
        cnt <= CNT_BITS'(QUO_BITS);
      end
      DV_RUN: begin
        rem <= ge ? trial[DEN_BITS-1:0] : trial_in[DEN_BITS-1:0];
        sh  <= {sh[QUO_BITS-2:0], ge};
        cnt <= cnt - CNT_BITS'(1);
      end
      DV_FIN: begin
        quo <= neg_r ? (~mag[COEF_BITS-1:0] + COEF_BITS'(1)) : mag[COEF_BITS-1:0];
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ design/mcs_seq.sv @@
// ----------------------------------------------------------------------------
// mcs_seq
// Sequencer and datapath: slopes, tangents and segment coefficients on one
// shared multiplier and the shared divider.
// ----------------------------------------------------------------------------
module mcs_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [mcs_pkg::POINT_BITS-1:0]      x,
  input  logic [mcs_pkg::POINT_BITS-1:0]      y,
  input  logic                                last_point,
  output logic                                idle,
  output mcs_pkg::div_req_t                   div_req,
  input  mcs_pkg::div_rsp_t                   div_rsp,
  input  logic                                out_free,
  output logic                                wr,
  output mcs_pkg::seg_t                       word
);
  import mcs_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  logic [1:0]                  points_seen;
  logic [POINT_BITS-1:0]       prev_x, prev_y, start_x, start_y, prev_dx;
  logic signed [COEF_BITS-1:0] prev_slope, start_tangent;
  logic [POINT_BITS-1:0]       in_x, in_y, dx_r, dy_mag;
  logic                        in_last, dy_neg;
  logic signed [COEF_BITS-1:0] m_new, c1, quad_r, cub_r;
  logic [COEF_BITS-1:0]        prod_hi;
  logic [NUM_BITS-1:0]         acc;
  logic [DEN_BITS-1:0]         den_r;
  logic [2*POINT_BITS-1:0]     dxsq;
  logic [POINT_BITS-1:0]       e_sx, e_sy, e_dx;
  logic signed [COEF_BITS-1:0] e_c1a, e_c1b, e_m;
  logic                        e_last, phase_b;
  logic [MUL_BITS-1:0]         mul_a, mul_b;
  logic [PROD_BITS-1:0]        mul_q;
  logic [POINT_BITS+2:0]       fac;
  logic [EXT_BITS-1:0]         common, qn;
  logic                        flat;

  assign fac    = (POINT_BITS+3)'(3) *
                  ((POINT_BITS+3)'(prev_dx) + (POINT_BITS+3)'(dx_r));
  assign common = EXT_BITS'(e_c1a) + EXT_BITS'(e_c1b) - (EXT_BITS'(e_m) <<< 1);
  assign qn     = EXT_BITS'(e_m) - EXT_BITS'(e_c1a) - common;
  // Neighboring slopes that touch zero or change sign force a flat tangent.
  assign flat   = (prev_slope == '0) || (div_rsp.quo == '0) ||
                  (prev_slope[COEF_BITS-1] != div_rsp.quo[COEF_BITS-1]);
  assign idle   = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_req.start = 1'b0;
    div_req.neg   = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    mul_a         = '0;
    mul_b         = '0;
    wr            = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid && points_seen != 2'd0) state_next = S_SLOPE;
      S_SLOPE: begin
        div_req.start = 1'b1;
        div_req.neg   = dy_neg;
        div_req.num   = NUM_BITS'({dy_mag, {POINT_BITS{1'b0}}});
        div_req.den   = DEN_BITS'(dx_r);
        state_next    = S_SLOPE_W;
      end
      S_SLOPE_W: begin
        if (div_rsp.done) begin
          if (points_seen == 2'd1) state_next = S_UPDATE;
          else if (flat) state_next = S_SETUP_A;
          else state_next = S_M0;
        end
      end
      S_M0: begin
        mul_a = MUL_BITS'(coef_mag(prev_slope));
        mul_b = MUL_BITS'(coef_mag(m_new));
        state_next = S_M1;
      end
      S_M1: begin
        mul_a = MUL_BITS'(mul_q[COEF_BITS-1:0]);
        mul_b = MUL_BITS'(fac);
        state_next = S_M2;
      end
      S_M2: begin
        mul_a = MUL_BITS'(prod_hi);
        mul_b = MUL_BITS'(fac);
        state_next = S_M3;
      end
      S_M3: begin
        mul_a = MUL_BITS'((POINT_BITS+2)'(prev_dx) + ((POINT_BITS+2)'(dx_r) << 1));
        mul_b = MUL_BITS'(coef_mag(m_new));
        state_next = S_M4;
      end
      S_M4: begin
        mul_a = MUL_BITS'(((POINT_BITS+2)'(prev_dx) << 1) + (POINT_BITS+2)'(dx_r));
        mul_b = MUL_BITS'(coef_mag(prev_slope));
        state_next = S_M5;
      end
      S_M5: state_next = S_TDIV;
      S_TDIV: begin
        div_req.start = 1'b1;
        div_req.neg   = prev_slope[COEF_BITS-1];
        div_req.num   = acc;
        div_req.den   = den_r;
        state_next    = S_TDIV_W;
      end
      S_TDIV_W: if (div_rsp.done) state_next = S_SETUP_A;
      S_SETUP_A: state_next = S_QDIV;
      S_UPDATE: state_next = in_last ? S_QDIV : S_IDLE;
      S_QDIV: begin
        div_req.start = 1'b1;
        div_req.neg   = qn[EXT_BITS-1];
        div_req.num   = NUM_BITS'({ext_mag(qn), {POINT_BITS{1'b0}}});
        div_req.den   = DEN_BITS'(e_dx);
        state_next    = S_QDIV_W;
      end
      S_QDIV_W: if (div_rsp.done) state_next = S_SQ0;
      S_SQ0: begin
        mul_a = MUL_BITS'(e_dx);
        mul_b = MUL_BITS'(e_dx);
        state_next = S_SQ1;
      end
      S_SQ1: state_next = S_CDIV;
      S_CDIV: begin
        div_req.start = 1'b1;
        div_req.neg   = common[EXT_BITS-1];
        div_req.num   = NUM_BITS'({ext_mag(common), {(2*POINT_BITS){1'b0}}});
        div_req.den   = DEN_BITS'(dxsq);
        state_next    = S_CDIV_W;
      end
      S_CDIV_W: if (div_rsp.done) state_next = S_WRITE;
      S_WRITE: begin
        if (out_free) begin
          wr = 1'b1;
          state_next = phase_b ? S_IDLE : S_UPDATE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
      prev_x <= '0;
      prev_y <= '0;
      start_x <= '0;
      start_y <= '0;
      prev_dx <= '0;
      prev_slope <= '0;
      start_tangent <= '0;
    end else begin
      if (state == S_IDLE && in_valid) begin
        if (points_seen == 2'd0) begin
          prev_x <= x;
          prev_y <= y;
          points_seen <= last_point ? 2'd0 : 2'd1;
        end
      end else if (state == S_UPDATE) begin
        start_x <= prev_x;
        start_y <= prev_y;
        start_tangent <= c1;
        prev_slope <= m_new;
        prev_dx <= dx_r;
        prev_x <= in_x;
        prev_y <= in_y;
        points_seen <= in_last ? 2'd0 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        in_x    <= x;
        in_y    <= y;
        in_last <= last_point;
        dx_r    <= (x >= prev_x) ? (x - prev_x) : '0;
        dy_neg  <= (y < prev_y);
        dy_mag  <= (y < prev_y) ? (prev_y - y) : (y - prev_y);
      end
      S_SLOPE_W: begin
        if (div_rsp.done) begin
          m_new <= div_rsp.quo;
          c1    <= (points_seen == 2'd1) ? div_rsp.quo : '0;
        end
      end
      S_M1: prod_hi <= mul_q[2*COEF_BITS-1:COEF_BITS];
      S_M2: acc <= NUM_BITS'(mul_q);
      S_M3: acc <= acc + (NUM_BITS'(mul_q) << COEF_BITS);
      S_M4: den_r <= DEN_BITS'(mul_q);
      S_M5: den_r <= den_r + DEN_BITS'(mul_q);
      S_TDIV_W: if (div_rsp.done) c1 <= div_rsp.quo;
      S_SETUP_A: begin
        e_sx    <= start_x;
        e_sy    <= start_y;
        e_c1a   <= start_tangent;
        e_c1b   <= c1;
        e_m     <= prev_slope;
        e_dx    <= prev_dx;
        e_last  <= 1'b0;
        phase_b <= 1'b0;
      end
      S_UPDATE: begin
        // The closing segment starts at the point held before this one.
        e_sx    <= prev_x;
        e_sy    <= prev_y;
        e_c1a   <= c1;
        e_c1b   <= m_new;
        e_m     <= m_new;
        e_dx    <= dx_r;
        e_last  <= 1'b1;
        phase_b <= 1'b1;
      end
      S_QDIV_W: if (div_rsp.done) quad_r <= div_rsp.quo;
      S_SQ1: dxsq <= mul_q[2*POINT_BITS-1:0];
      S_CDIV_W: if (div_rsp.done) cub_r <= div_rsp.quo;
      default: ;
    endcase
  end

  assign word.seg_x        = e_sx;
  assign word.seg_y        = e_sy;
  assign word.tangent      = e_c1a;
  assign word.quad_coef    = quad_r;
  assign word.cubic_coef   = cub_r;
  assign word.last_segment = e_last;

endmodule

@@ design/monotone_cubic_segment_coeffs_top.sv @@
// ----------------------------------------------------------------------------
// monotone_cubic_segment_coeffs_top
// Monotone cubic Hermite segment builder with an output word register.
// ----------------------------------------------------------------------------
// Points enter on the input channel (x, y, last_point) in ascending x order.
// Each segment leaves as one word on the output channel: start point, tangent,
// quadratic and cubic coefficients, and a flag on the final segment.
// A segment is sent once the point after its end arrives; the last point of a
// curve of three or more points sends two words (one for a two-point curve),
// and a curve's first point sends none. Every division runs on one shared
// restoring divider and holds the sequencer until it is done; it ends early when
// the numerator or divisor is zero or the quotient overflows the divider's
// quotient bits. A second point takes a slope division, an interior point a slope,
// a tangent and two coefficient divisions (no tangent division when the tangent
// is flat), and a last point two more coefficient divisions for its closing segment.
// in_ready is high only while the sequencer is idle, so points go one at a time.
// Words wait in the output register; a stalled receiver holds the sequencer
// before its next write but not before it returns to idle for a new point.
// Synchronous reset empties the block and the next point starts a new curve.
// ----------------------------------------------------------------------------
module monotone_cubic_segment_coeffs_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mcs_pkg::POINT_BITS-1:0]      x,
  input  logic [mcs_pkg::POINT_BITS-1:0]      y,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcs_pkg::POINT_BITS-1:0]      seg_x,
  output logic [mcs_pkg::POINT_BITS-1:0]      seg_y,
  output logic signed [mcs_pkg::COEF_BITS-1:0] tangent,
  output logic signed [mcs_pkg::COEF_BITS-1:0] quad_coef,
  output logic signed [mcs_pkg::COEF_BITS-1:0] cubic_coef,
  output logic                                last_segment
);
  import mcs_pkg::*;

  div_req_t div_req;
  div_rsp_t div_rsp;
  seg_t     word;
  seg_t     out_word;
  logic     wr;
  logic     idle;
  logic     out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = idle;

  mcs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .x          (x),
    .y          (y),
    .last_point (last_point),
    .idle       (idle),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_free   (out_free),
    .wr         (wr),
    .word       (word)
  );

  mcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      out_word <= word;
    end
  end

  assign seg_x        = out_word.seg_x;
  assign seg_y        = out_word.seg_y;
  assign tangent      = out_word.tangent;
  assign quad_coef    = out_word.quad_coef;
  assign cubic_coef   = out_word.cubic_coef;
  assign last_segment = out_word.last_segment;

endmodule

@@ design/mcs_chk.sv @@
// ----------------------------------------------------------------------------
// mcs_chk
// Port-level checks for the monotone cubic segment builder.
// ----------------------------------------------------------------------------
module mcs_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [mcs_pkg::POINT_BITS-1:0]      seg_x,
  input logic [mcs_pkg::POINT_BITS-1:0]      seg_y,
  input logic signed [mcs_pkg::COEF_BITS-1:0] tangent,
  input logic signed [mcs_pkg::COEF_BITS-1:0] quad_coef,
  input logic signed [mcs_pkg::COEF_BITS-1:0] cubic_coef,
  input logic                                last_segment
);

  // Reset leaves the block empty and ready for a point.
  a_reset_idle: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  // A stalled word stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(seg_x) && $stable(seg_y) &&
                                   $stable(tangent) && $stable(quad_coef) &&
                                   $stable(cubic_coef) && $stable(last_segment)))
    else $error("output word changed while stalled");

  // An offered word carries no unknown bits.
  a_word_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({seg_x, seg_y, tangent, quad_coef, cubic_coef,
                               last_segment}))
    else $error("output word has unknown bits");

endmodule

bind monotone_cubic_segment_coeffs_top mcs_chk u_chk (.*);
